FILE: rtl/cdc_pkg.sv
// cdc_pkg: shared types, constants and calendar helpers for the date counter
// used by cdc_front, cdc_queue, cdc_back and calendar_date_counter_unit
// no dependencies
package cdc_pkg;

	typedef enum logic [1:0] {
		FN_LOAD = 2'd0,
		FN_INC  = 2'd1,
		FN_DEC  = 2'd2,
		FN_CMP  = 2'd3
	} func_t;

	localparam logic [13:0] YEAR_MIN   = 14'd1900;
	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam logic [8:0]  R400_RESET = 9'd300;
	localparam logic [8:0]  R400_LAST  = 9'd399;

	typedef struct packed {
		func_t       func;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [2:0]  weekday;
		logic [8:0]  r400;
		logic        ok;
	} cdc_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cdc_qstat_t;

	// leap year from the year modulo 400
	function automatic logic leap_of(input logic [8:0] r);
		leap_of = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	// month length, zero for a month outside 1..12
	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2: n = leap ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		days_in = n;
	endfunction

endpackage

FILE: rtl/cdc_queue.sv
// cdc_queue: short fifo of decoded items between front and back
// depends on cdc_pkg
module cdc_queue
	import cdc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cdc_item_t  push_item,
	input  logic       pop,
	output cdc_item_t  head_item,
	output cdc_qstat_t qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cdc_item_t     mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);
	assign head_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty)) else $error("pop from empty queue");

endmodule

FILE: rtl/cdc_front.sv
// cdc_front: accepts items, validates loads and works out the weekday and year phase
// three stage pipeline feeding cdc_queue; depends on cdc_pkg
module cdc_front
	import cdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  func,
	input  logic [4:0]  in_day,
	input  logic [3:0]  in_month,
	input  logic [13:0] in_year,
	input  cdc_qstat_t  qstat,
	output logic        push,
	output cdc_item_t   push_item
);

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd2:  n = 9'd31;
			4'd3:  n = 9'd59;
			4'd4:  n = 9'd90;
			4'd5:  n = 9'd120;
			4'd6:  n = 9'd151;
			4'd7:  n = 9'd181;
			4'd8:  n = 9'd212;
			4'd9:  n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			4'd12: n = 9'd334;
			default: n = 9'd0;
		endcase
		days_before = n;
	endfunction

	// modulo 7 by folding octal digits
	function automatic logic [2:0] mod7(input logic [13:0] s);
		logic [4:0] f;
		logic [3:0] g;
		f = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[11:9]) + 5'(s[13:12]);
		g = 4'(f[2:0]) + 4'(f[4:3]);
		mod7 = (g >= 4'd7) ? 3'(g - 4'd7) : g[2:0];
	endfunction

	logic rdy1, rdy2, rdy3;
	logic v_s1, v_s2, v_s3;

	// stage 1
	func_t       func_s1;
	logic [4:0]  day_s1;
	logic [3:0]  mon_s1;
	logic [13:0] year_s1;
	logic [11:0] q4_s1;
	logic [7:0]  q100_s1;
	logic [5:0]  q400_s1;

	// stage 2
	func_t       func_s2;
	logic [4:0]  day_s2;
	logic [3:0]  mon_s2;
	logic [13:0] year_s2;
	logic [13:0] sum_s2;
	logic [8:0]  r400_s2;
	logic        ok_s2;

	// stage 3
	func_t       func_s3;
	logic [4:0]  day_s3;
	logic [3:0]  mon_s3;
	logic [13:0] year_s3;
	logic [2:0]  wd_s3;
	logic [8:0]  r400_s3;
	logic        ok_s3;

	logic [13:0] ym1_in;
	logic [24:0] p100;
	logic [22:0] p400;

	logic [13:0] ym1_c;
	logic [13:0] rm_c;
	logic [8:0]  r400_c;
	logic        leap_c;
	logic [4:0]  mlen_c;
	logic        ok_c;
	logic [13:0] sum_c;

	assign rdy3      = !v_s3 || !qstat.full;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign cmd_stall = !rdy1;
	assign push      = v_s3 && !qstat.full;

	assign ym1_in = in_year - 14'd1;
	assign p100   = 25'({13'd0, ym1_in[13:2]}) * 25'd5243;
	assign p400   = 23'({13'd0, ym1_in[13:4]}) * 23'd5243;

	always_comb begin
		ym1_c  = year_s1 - 14'd1;
		rm_c   = ym1_c - 14'({8'd0, q400_s1} * 14'd400);
		r400_c = (rm_c[8:0] == R400_LAST) ? 9'd0 : rm_c[8:0] + 9'd1;
		leap_c = leap_of(r400_c);
		mlen_c = days_in(mon_s1, leap_c);
		ok_c   = (year_s1 >= YEAR_MIN) && (year_s1 <= YEAR_MAX)
			&& (day_s1 != 5'd0) && (day_s1 <= mlen_c);
		sum_c  = (year_s1 - YEAR_MIN)
			+ 14'(q4_s1) - 14'(q100_s1) + 14'(q400_s1) - 14'd460
			+ 14'(days_before(mon_s1))
			+ 14'((mon_s1 > 4'd2) && leap_c)
			+ 14'(day_s1) - 14'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= cmd_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && cmd_valid) begin
			func_s1 <= func_t'(func);
			day_s1  <= in_day;
			mon_s1  <= in_month;
			year_s1 <= in_year;
			q4_s1   <= ym1_in[13:2];
			q100_s1 <= p100[24:17];
			q400_s1 <= p400[22:17];
		end
		if (rdy2 && v_s1) begin
			func_s2 <= func_s1;
			day_s2  <= day_s1;
			mon_s2  <= mon_s1;
			year_s2 <= year_s1;
			sum_s2  <= sum_c;
			r400_s2 <= r400_c;
			ok_s2   <= ok_c;
		end
		if (rdy3 && v_s2) begin
			func_s3 <= func_s2;
			day_s3  <= day_s2;
			mon_s3  <= mon_s2;
			year_s3 <= year_s2;
			wd_s3   <= mod7(sum_s2);
			r400_s3 <= r400_s2;
			ok_s3   <= ok_s2;
		end
	end

	always_comb begin
		push_item.func    = func_s3;
		push_item.day     = day_s3;
		push_item.month   = mon_s3;
		push_item.year    = year_s3;
		push_item.weekday = wd_s3;
		push_item.r400    = r400_s3;
		push_item.ok      = ok_s3;
	end

endmodule

FILE: rtl/cdc_back.sv
// cdc_back: holds the stored date and carries out queued items
// registered result stage; depends on cdc_pkg
module cdc_back
	import cdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cdc_item_t   head_item,
	input  cdc_qstat_t  qstat,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [4:0]  out_day,
	output logic [3:0]  out_month,
	output logic [13:0] out_year,
	output logic [2:0]  weekday,
	output logic        valid_res,
	output logic        stored_less,
	output logic        stored_less_equal,
	output logic        stored_equal
);

	logic [4:0]  cur_day_q;
	logic [3:0]  cur_month_q;
	logic [13:0] cur_year_q;
	logic [2:0]  cur_wd_q;
	logic [8:0]  cur_r400_q;
	logic        res_valid_q;

	logic        leap_cur;
	logic [4:0]  mlen_cur;
	logic [4:0]  nx_day;
	logic [3:0]  nx_month;
	logic [13:0] nx_year;
	logic [2:0]  nx_wd;
	logic [8:0]  nx_r400;
	logic        ok, lt, le, eq;
	logic [22:0] key_cur, key_in;

	assign pop       = !qstat.empty && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign leap_cur  = leap_of(cur_r400_q);
	assign mlen_cur  = days_in(cur_month_q, leap_cur);
	assign key_cur   = {cur_year_q, cur_month_q, cur_day_q};
	assign key_in    = {head_item.year, head_item.month, head_item.day};

	always_comb begin
		nx_day   = cur_day_q;
		nx_month = cur_month_q;
		nx_year  = cur_year_q;
		nx_wd    = cur_wd_q;
		nx_r400  = cur_r400_q;
		ok       = 1'b1;
		lt       = 1'b0;
		le       = 1'b0;
		eq       = 1'b0;
		case (head_item.func)
			FN_LOAD: begin
				ok = head_item.ok;
				if (head_item.ok) begin
					nx_day   = head_item.day;
					nx_month = head_item.month;
					nx_year  = head_item.year;
					nx_wd    = head_item.weekday;
					nx_r400  = head_item.r400;
				end
			end
			FN_INC: begin
				if (cur_day_q < mlen_cur) begin
					nx_day = cur_day_q + 5'd1;
				end else if (cur_month_q < 4'd12) begin
					nx_day   = 5'd1;
					nx_month = cur_month_q + 4'd1;
				end else if (cur_year_q < YEAR_MAX) begin
					nx_day   = 5'd1;
					nx_month = 4'd1;
					nx_year  = cur_year_q + 14'd1;
					nx_r400  = (cur_r400_q == R400_LAST) ? 9'd0 : cur_r400_q + 9'd1;
				end else begin
					ok = 1'b0;
				end
				if (ok) begin
					nx_wd = (cur_wd_q == 3'd6) ? 3'd0 : cur_wd_q + 3'd1;
				end
			end
			FN_DEC: begin
				if (cur_day_q > 5'd1) begin
					nx_day = cur_day_q - 5'd1;
				end else if (cur_month_q > 4'd1) begin
					nx_month = cur_month_q - 4'd1;
					nx_day   = days_in(cur_month_q - 4'd1, leap_cur);
				end else if (cur_year_q > YEAR_MIN) begin
					nx_year  = cur_year_q - 14'd1;
					nx_month = 4'd12;
					nx_day   = 5'd31;
					nx_r400  = (cur_r400_q == 9'd0) ? R400_LAST : cur_r400_q - 9'd1;
				end else begin
					ok = 1'b0;
				end
				if (ok) begin
					nx_wd = (cur_wd_q == 3'd0) ? 3'd6 : cur_wd_q - 3'd1;
				end
			end
			FN_CMP: begin
				lt = key_cur < key_in;
				le = key_cur <= key_in;
				eq = key_cur == key_in;
			end
			default: begin
				ok = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= 5'd1;
			cur_month_q <= 4'd1;
			cur_year_q  <= YEAR_MIN;
			cur_wd_q    <= 3'd0;
			cur_r400_q  <= R400_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_day_q   <= nx_day;
				cur_month_q <= nx_month;
				cur_year_q  <= nx_year;
				cur_wd_q    <= nx_wd;
				cur_r400_q  <= nx_r400;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_day           <= nx_day;
			out_month         <= nx_month;
			out_year          <= nx_year;
			weekday           <= nx_wd;
			valid_res         <= ok;
			stored_less       <= lt;
			stored_less_equal <= le;
			stored_equal      <= eq;
		end
	end

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cur_day_q != 5'd0 && cur_day_q <= mlen_cur) else $error("stored day out of month");
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_year_q >= YEAR_MIN && cur_year_q <= YEAR_MAX && cur_r400_q <= R400_LAST
		&& cur_wd_q <= 3'd6) else $error("stored date out of range");
	a_cmp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_item.func == FN_CMP |=> $stable(cur_day_q) && $stable(cur_month_q)
		&& $stable(cur_year_q) && $stable(cur_wd_q)) else $error("compare changed state");

endmodule

FILE: rtl/calendar_date_counter_unit.sv
// calendar_date_counter_unit: gregorian date counter with weekday
// instantiates cdc_front, cdc_queue and cdc_back; depends on cdc_pkg
//
// command channel: cmd_valid/cmd_stall with func, in_day, in_month, in_year
//   func selects load, increment, decrement or compare against the given date
// result channel: res_valid/res_stall, one result item per command item,
//   carrying the stored date and weekday after the command and the flags
// an accepted item passes the three front stages (reciprocal divides,
//   day sum, modulo 7 fold) and the queue; then the back stage updates the
//   stored date and loads the output register that shows the result
// throughput: one item per cycle, sustained, with both sides flowing
// a receiver stall holds the result; the queue of QUEUE_DEPTH entries then
//   fills and cmd_stall rises once the front pipeline is also full
// reset: stored date becomes 1 Jan 1900, a Monday, and all pipes empty
module calendar_date_counter_unit
	import cdc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  func,
	input  logic [4:0]  in_day,
	input  logic [3:0]  in_month,
	input  logic [13:0] in_year,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [4:0]  out_day,
	output logic [3:0]  out_month,
	output logic [13:0] out_year,
	output logic [2:0]  weekday,
	output logic        valid_res,
	output logic        stored_less,
	output logic        stored_less_equal,
	output logic        stored_equal
);

	cdc_qstat_t qstat;
	cdc_item_t  push_item;
	cdc_item_t  head_item;
	logic       push;
	logic       pop;

	cdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.func      (func),
		.in_day    (in_day),
		.in_month  (in_month),
		.in_year   (in_year),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	cdc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.qstat     (qstat)
	);

	cdc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_item         (head_item),
		.qstat             (qstat),
		.pop               (pop),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.out_day           (out_day),
		.out_month         (out_month),
		.out_year          (out_year),
		.weekday           (weekday),
		.valid_res         (valid_res),
		.stored_less       (stored_less),
		.stored_less_equal (stored_less_equal),
		.stored_equal      (stored_equal)
	);

endmodule
